### sv/fec16_pkg.sv
// ----------------------------------------------------------------------------
// fec16_pkg - shared types and constants of the frame encoder
// Command format between front and back end, queue status, field codes and
// the bytewise crc-16 update.
// ----------------------------------------------------------------------------
package fec16_pkg;

  // packed input word width: five header bytes, two 16-bit words, data byte
  localparam int IN_DATA_W = 80;

  // operation codes carried on in_tuser
  localparam logic OP_START   = 1'b0;
  localparam logic OP_PAYLOAD = 1'b1;

  // error codes carried on out_tuser
  localparam logic [1:0] ERR_NONE = 2'd0;
  localparam logic [1:0] ERR_LEN  = 2'd1;
  localparam logic [1:0] ERR_PAY  = 2'd2;

  // configuration register indexes
  localparam logic REG_CRC_INIT    = 1'b0;
  localparam logic REG_MAX_PAYLOAD = 1'b1;

  // configuration reset values
  localparam logic [15:0] CRC_INIT_RST    = 16'hFFFF;
  localparam logic [15:0] MAX_PAYLOAD_RST = 16'd1024;

  // sync pattern and generator polynomial
  localparam logic [7:0]  SYNC_HI  = 8'hA5;
  localparam logic [7:0]  SYNC_LO  = 8'h5A;
  localparam logic [15:0] CRC_POLY = 16'h1021;

  // command kinds handed from front to back end
  typedef logic [1:0] cmd_kind_t;
  localparam cmd_kind_t CMD_HDR     = 2'd0;
  localparam cmd_kind_t CMD_PAY     = 2'd1;
  localparam cmd_kind_t CMD_ERR_LEN = 2'd2;
  localparam cmd_kind_t CMD_ERR_PAY = 2'd3;

  // one classified command; last marks a crc trailer after this command
  typedef struct packed {
    cmd_kind_t   kind;
    logic        last;
    logic [7:0]  version;
    logic [7:0]  destination;
    logic [7:0]  source;
    logic [7:0]  message_type;
    logic [7:0]  frame_flags;
    logic [15:0] sequence_number;
    logic [15:0] payload_length;
    logic [7:0]  data_byte;
  } cmd_t;

  // queue status seen by both ends
  typedef struct packed {
    logic empty;
    logic full;
  } q_stat_t;

  // crc-16 update with one byte, msb first, no reflection
  function automatic logic [15:0] crc16_feed(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

### sv/fec16_front.sv
// ----------------------------------------------------------------------------
// fec16_front - input side of the frame encoder
// Accepts input words, tracks the open frame and classifies each word into
// a header, payload or error command for the queue.
// ----------------------------------------------------------------------------
module fec16_front (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [fec16_pkg::IN_DATA_W-1:0]     in_tdata,
  input  logic                                in_tuser,
  input  logic [15:0]                         max_payload,
  input  fec16_pkg::q_stat_t                  q_stat,
  output logic                                q_push,
  output fec16_pkg::cmd_t                     q_cmd
);
  import fec16_pkg::*;

  logic        frame_open_r, frame_open_nxt;
  logic [15:0] remain_r, remain_nxt;

  // take a word whenever the queue has room
  assign in_tready = !q_stat.full;
  assign q_push    = in_tvalid && in_tready;

  // unpack fields and classify
  always_comb begin
    q_cmd.version         = in_tdata[7:0];
    q_cmd.destination     = in_tdata[15:8];
    q_cmd.source          = in_tdata[23:16];
    q_cmd.message_type    = in_tdata[31:24];
    q_cmd.frame_flags     = in_tdata[39:32];
    q_cmd.sequence_number = in_tdata[55:40];
    q_cmd.payload_length  = in_tdata[71:56];
    q_cmd.data_byte       = in_tdata[79:72];
    q_cmd.kind            = CMD_ERR_PAY;
    q_cmd.last            = 1'b0;
    frame_open_nxt        = frame_open_r;
    remain_nxt            = remain_r;
    if (in_tuser == OP_START) begin
      // a new start abandons any open frame
      frame_open_nxt = 1'b0;
      remain_nxt     = 16'd0;
      if (q_cmd.payload_length > max_payload) begin
        q_cmd.kind = CMD_ERR_LEN;
      end else begin
        q_cmd.kind     = CMD_HDR;
        q_cmd.last     = (q_cmd.payload_length == 16'd0);
        frame_open_nxt = (q_cmd.payload_length != 16'd0);
        remain_nxt     = q_cmd.payload_length;
      end
    end else if (frame_open_r && (remain_r != 16'd0)) begin
      q_cmd.kind     = CMD_PAY;
      q_cmd.last     = (remain_r == 16'd1);
      remain_nxt     = remain_r - 16'd1;
      frame_open_nxt = (remain_r != 16'd1);
    end
  end

  // frame tracking state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_open_r <= 1'b0;
      remain_r     <= 16'd0;
    end else if (q_push) begin
      frame_open_r <= frame_open_nxt;
      remain_r     <= remain_nxt;
    end
  end

endmodule

### sv/fec16_queue.sv
// ----------------------------------------------------------------------------
// fec16_queue - command queue between front and back end
// Small register fifo; the head entry is visible to the back end directly.
// ----------------------------------------------------------------------------
module fec16_queue #(
  parameter int DEPTH = 4
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  fec16_pkg::cmd_t    push_cmd,
  input  logic               pop,
  output fec16_pkg::cmd_t    head_cmd,
  output fec16_pkg::q_stat_t stat
);
  import fec16_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  cmd_t          mem_r [DEPTH];
  logic [AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] count_r;

  assign stat.empty = (count_r == CW'(0));
  assign stat.full  = (count_r == CW'(DEPTH));
  assign head_cmd   = mem_r[rd_ptr_r];

  // storage, no reset needed
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + AW'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + AW'(1);
      end
      if (push && !pop) begin
        count_r <= count_r + CW'(1);
      end else if (pop && !push) begin
        count_r <= count_r - CW'(1);
      end
    end
  end

  // fill count stays in range
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("queue fill count out of range");

  // no push into a full queue, no pop from an empty one
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && stat.full) && !(pop && stat.empty))
    else $error("queue overrun or underrun");

  // a lone pop lowers the count by one
  a_pop_count: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && !push) |=> (count_r == $past(count_r) - CW'(1)))
    else $error("queue count not reduced on pop");

endmodule

### sv/fec16_back.sv
// ----------------------------------------------------------------------------
// fec16_back - byte sequencer of the frame encoder
// Walks the head command byte by byte, keeps the running crc and drives the
// registered output word.
// ----------------------------------------------------------------------------
module fec16_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [15:0]        crc_init,
  input  fec16_pkg::cmd_t    head_cmd,
  input  fec16_pkg::q_stat_t q_stat,
  output logic               q_pop,
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic [7:0]         out_tdata,
  output logic               out_tlast,
  output logic [1:0]         out_tuser
);
  import fec16_pkg::*;

  // byte positions within a header command
  localparam logic [3:0] STEP_SYNC_HI  = 4'd0;
  localparam logic [3:0] STEP_SYNC_LO  = 4'd1;
  localparam logic [3:0] STEP_VERSION  = 4'd2;
  localparam logic [3:0] STEP_DEST     = 4'd3;
  localparam logic [3:0] STEP_SOURCE   = 4'd4;
  localparam logic [3:0] STEP_TYPE     = 4'd5;
  localparam logic [3:0] STEP_FLAGS    = 4'd6;
  localparam logic [3:0] STEP_SEQ_LO   = 4'd7;
  localparam logic [3:0] STEP_SEQ_HI   = 4'd8;
  localparam logic [3:0] STEP_LEN_LO   = 4'd9;
  localparam logic [3:0] STEP_LEN_HI   = 4'd10;
  localparam logic [3:0] STEP_HCRC_LO  = 4'd11;
  localparam logic [3:0] STEP_HCRC_HI  = 4'd12;
  // byte positions within a payload command
  localparam logic [3:0] STEP_DATA     = 4'd0;
  localparam logic [3:0] STEP_PCRC_LO  = 4'd1;
  localparam logic [3:0] STEP_PCRC_HI  = 4'd2;

  logic [3:0]  step_r, step_nxt;
  logic [15:0] crc_r, crc_nxt;
  logic        vld_r;
  logic [7:0]  byte_r;
  logic        last_r;
  logic [1:0]  err_r;

  logic        emit;
  logic        final_step;
  logic        feed;
  logic [7:0]  byte_sel;
  logic        eof_sel;
  logic [1:0]  err_sel;

  // advance when a command waits and the output slot is free or draining
  assign emit  = !q_stat.empty && (!vld_r || out_tready);
  assign q_pop = emit && final_step;

  // select the byte for the current step
  always_comb begin
    byte_sel   = 8'h00;
    eof_sel    = 1'b0;
    err_sel    = ERR_NONE;
    feed       = 1'b0;
    final_step = 1'b0;
    case (head_cmd.kind)
      CMD_HDR: begin
        feed = 1'b1;
        case (step_r)
          STEP_SYNC_HI: begin
            byte_sel = SYNC_HI;
            feed     = 1'b0;
          end
          STEP_SYNC_LO: begin
            byte_sel = SYNC_LO;
            feed     = 1'b0;
          end
          STEP_VERSION: byte_sel = head_cmd.version;
          STEP_DEST:    byte_sel = head_cmd.destination;
          STEP_SOURCE:  byte_sel = head_cmd.source;
          STEP_TYPE:    byte_sel = head_cmd.message_type;
          STEP_FLAGS:   byte_sel = head_cmd.frame_flags;
          STEP_SEQ_LO:  byte_sel = head_cmd.sequence_number[7:0];
          STEP_SEQ_HI:  byte_sel = head_cmd.sequence_number[15:8];
          STEP_LEN_LO:  byte_sel = head_cmd.payload_length[7:0];
          STEP_LEN_HI: begin
            byte_sel   = head_cmd.payload_length[15:8];
            final_step = !head_cmd.last;
          end
          STEP_HCRC_LO: begin
            byte_sel = crc_r[7:0];
            feed     = 1'b0;
          end
          STEP_HCRC_HI: begin
            byte_sel   = crc_r[15:8];
            eof_sel    = 1'b1;
            feed       = 1'b0;
            final_step = 1'b1;
          end
          default: begin
            feed       = 1'b0;
            final_step = 1'b1;
          end
        endcase
      end
      CMD_PAY: begin
        case (step_r)
          STEP_DATA: begin
            byte_sel   = head_cmd.data_byte;
            feed       = 1'b1;
            final_step = !head_cmd.last;
          end
          STEP_PCRC_LO: byte_sel = crc_r[7:0];
          STEP_PCRC_HI: begin
            byte_sel   = crc_r[15:8];
            eof_sel    = 1'b1;
            final_step = 1'b1;
          end
          default: final_step = 1'b1;
        endcase
      end
      CMD_ERR_LEN: begin
        eof_sel    = 1'b1;
        err_sel    = ERR_LEN;
        final_step = 1'b1;
      end
      default: begin
        eof_sel    = 1'b1;
        err_sel    = ERR_PAY;
        final_step = 1'b1;
      end
    endcase
  end

  // next step and running crc
  always_comb begin
    step_nxt = final_step ? 4'd0 : step_r + 4'd1;
    crc_nxt  = crc_r;
    if ((head_cmd.kind == CMD_HDR) && (step_r == STEP_SYNC_HI)) begin
      crc_nxt = crc_init;
    end else if (feed) begin
      crc_nxt = crc16_feed(crc_r, byte_sel);
    end
  end

  // sequencer state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= 4'd0;
      crc_r  <= 16'd0;
    end else if (emit) begin
      step_r <= step_nxt;
      crc_r  <= crc_nxt;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (emit) begin
      vld_r <= 1'b1;
    end else if (out_tready) begin
      vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      byte_r <= byte_sel;
      last_r <= eof_sel;
      err_r  <= err_sel;
    end
  end

  assign out_tvalid = vld_r;
  assign out_tdata  = byte_r;
  assign out_tlast  = last_r;
  assign out_tuser  = err_r;

  // an error word carries a zero byte and closes the frame
  a_err_word: assert property (@(posedge clk) disable iff (!rst_n)
    (vld_r && (err_r != ERR_NONE)) |-> (last_r && (byte_r == 8'h00)))
    else $error("error word with data or without end marker");

  // the step counter rests at zero whenever a command is popped
  a_step_reset: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> (step_r == 4'd0))
    else $error("step counter not cleared after command");

endmodule

### sv/frame_encoder_crc16.sv
// ----------------------------------------------------------------------------
// frame_encoder_crc16 - framed byte stream encoder with crc-16 trailer
// Start words open a frame with sync, header and length; payload words add
// one byte each; a crc-16 (poly 0x1021) closes the frame, low byte first.
//
//   channel  dir  words                      sideband
//   in_      in   header / payload (80 bit)  tuser = operation
//   out_     out  one frame byte (8 bit)     tlast = end of frame, tuser = error
//   cfg_     in   register write (16 bit)    cfg_index selects register
//
// A payload word yields its data byte, plus the crc trailer if it ends a frame.
// A start word yields sync, header and length bytes, plus the trailer with zero
// length; error words yield one word. The back end byte sequencer sets this.
// Reset clears frame tracking, queue and output, and loads crc_init 0xFFFF and
// max_payload 1024. The queue takes input words while the output stalls, until full.
// ----------------------------------------------------------------------------
module frame_encoder_crc16 #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // version, destination, source, message_type, frame_flags,
  // sequence_number[15:0], payload_length[15:0], data_byte
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [fec16_pkg::IN_DATA_W-1:0] in_tdata,
  input  logic                            in_tuser,   // operation
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [7:0]                      out_tdata,  // out_byte
  output logic                            out_tlast,  // end_of_frame
  output logic [1:0]                      out_tuser,  // error_code
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic                            cfg_index,
  input  logic [15:0]                     cfg_data
);
  import fec16_pkg::*;

  logic [15:0] crc_init_r;
  logic [15:0] max_payload_r;

  logic        q_push, q_pop;
  cmd_t        push_cmd, head_cmd;
  q_stat_t     q_stat;

  // configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_init_r    <= CRC_INIT_RST;
      max_payload_r <= MAX_PAYLOAD_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_CRC_INIT:    crc_init_r    <= cfg_data;
        REG_MAX_PAYLOAD: max_payload_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // front end: accept and classify
  fec16_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .max_payload (max_payload_r),
    .q_stat      (q_stat),
    .q_push      (q_push),
    .q_cmd       (push_cmd)
  );

  // command queue
  fec16_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (push_cmd),
    .pop      (q_pop),
    .head_cmd (head_cmd),
    .stat     (q_stat)
  );

  // back end: byte sequencer and output register
  fec16_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .crc_init   (crc_init_r),
    .head_cmd   (head_cmd),
    .q_stat     (q_stat),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

endmodule

### test/tb_frame_encoder_crc16.sv
// ----------------------------------------------------------------------------
// tb - self-checking bench for the crc-16 frame encoder
// Start and payload words go in on the input stream, and a bytewise model
// predicts every frame byte, crc trailer and error word. The checker matches
// each output word against the oldest prediction. Both streams idle at random,
// the output is also held off for a long stretch, and the crc seed and the
// payload limit are changed between phases.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  import fec16_pkg::*;

  localparam int LIMIT_CYCLES  = 400000;
  localparam int SETTLE_CYCLES = 24;
  // bit offsets inside in_tdata
  localparam int SEQ_LSB  = 40;
  localparam int LEN_LSB  = 56;
  localparam int DATA_LSB = 72;
  localparam int HDR_BYTES = 9;

  typedef struct packed {
    logic [7:0] data;
    logic       eof;
    logic [1:0] err;
  } enc_out_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_tvalid = 1'b0;
  logic                 in_tready;
  logic [IN_DATA_W-1:0] in_tdata = '0;
  logic                 in_tuser = OP_START;
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic [7:0]           out_tdata;
  logic                 out_tlast;
  logic [1:0]           out_tuser;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic                 cfg_index = REG_CRC_INIT;
  logic [15:0]          cfg_data = '0;

  // predicted encoder state and registers
  logic [15:0] pred_crc_init = CRC_INIT_RST;
  logic [15:0] pred_max_len  = MAX_PAYLOAD_RST;
  logic        pred_open     = 1'b0;
  logic [15:0] pred_left     = '0;
  logic [15:0] pred_crc      = '0;

  enc_out_t frame_bytes_q[$];
  int       mismatch_count = 0;
  int       cycle_count = 0;
  bit       gaps_on = 1'b1;
  int       hold_left = 0;

  frame_encoder_crc16 u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("%0t: timeout with %0d bytes outstanding", $time, frame_bytes_q.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // prediction
  // ---------------------------------------------------------------------------

  // crc-16, one bit at a time from the msb
  function automatic logic [15:0] crc16_step(input logic [15:0] c, input logic [7:0] b);
    logic fb;
    for (int i = 7; i >= 0; i--) begin
      fb = c[15] ^ b[i];
      c  = {c[14:0], 1'b0};
      if (fb) begin
        c = c ^ CRC_POLY;
      end
    end
    return c;
  endfunction

  function automatic void want_byte(input logic [7:0] b, input logic eof, input logic [1:0] err);
    enc_out_t e;
    e.data = b;
    e.eof  = eof;
    e.err  = err;
    frame_bytes_q.push_back(e);
  endfunction

  function automatic void want_covered(input logic [7:0] b);
    pred_crc = crc16_step(pred_crc, b);
    want_byte(b, 1'b0, ERR_NONE);
  endfunction

  function automatic void want_trailer();
    want_byte(pred_crc[7:0], 1'b0, ERR_NONE);
    want_byte(pred_crc[15:8], 1'b1, ERR_NONE);
    pred_open = 1'b0;
    pred_left = '0;
  endfunction

  // bytes produced by one accepted input word
  function automatic void encode_word(input logic op, input logic [IN_DATA_W-1:0] d);
    logic [15:0] len;
    len = d[LEN_LSB +: 16];
    if (op == OP_START) begin
      // a start always drops whatever frame was open
      pred_open = 1'b0;
      pred_left = '0;
      if (len > pred_max_len) begin
        want_byte(8'h00, 1'b1, ERR_LEN);
      end else begin
        want_byte(SYNC_HI, 1'b0, ERR_NONE);
        want_byte(SYNC_LO, 1'b0, ERR_NONE);
        pred_crc = pred_crc_init;
        // header bytes sit in tdata in wire order, sequence and length low first
        for (int i = 0; i < HDR_BYTES; i++) begin
          want_covered(d[i*8 +: 8]);
        end
        if (len == 0) begin
          want_trailer();
        end else begin
          pred_open = 1'b1;
          pred_left = len;
        end
      end
    end else if (!pred_open || pred_left == 0) begin
      want_byte(8'h00, 1'b1, ERR_PAY);
    end else begin
      want_covered(d[DATA_LSB +: 8]);
      pred_left = pred_left - 16'd1;
      if (pred_left == 0) begin
        want_trailer();
      end
    end
  endfunction

  // ---------------------------------------------------------------------------
  // output side: random stalls, long hold-off and checking
  // ---------------------------------------------------------------------------

  // ready driver
  initial begin
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_tready = 1'b0;
        hold_left--;
      end else begin
        out_tready = !(gaps_on && $urandom_range(99) < 28);
      end
    end
  end

  // compare each output word with the oldest prediction
  always @(posedge clk) begin
    enc_out_t e;
    if (rst_n && out_tvalid && out_tready) begin
      if (frame_bytes_q.size() == 0) begin
        mismatch_count++;
        $display("%0t: unexpected word byte=%h last=%b err=%0d", $time,
                 out_tdata, out_tlast, out_tuser);
      end else begin
        e = frame_bytes_q.pop_front();
        if (out_tdata !== e.data) begin
          mismatch_count++;
          $display("%0t: out_byte expected %h actual %h", $time, e.data, out_tdata);
        end
        if (out_tlast !== e.eof) begin
          mismatch_count++;
          $display("%0t: end_of_frame expected %b actual %b", $time, e.eof, out_tlast);
        end
        if (out_tuser !== e.err) begin
          mismatch_count++;
          $display("%0t: error_code expected %0d actual %0d", $time, e.err, out_tuser);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // input side
  // ---------------------------------------------------------------------------

  function automatic logic [IN_DATA_W-1:0] pack_word(
    input logic [7:0] ver, dst, src, typ, flg,
    input logic [15:0] seq, len,
    input logic [7:0] dat
  );
    return {dat, len, seq, flg, typ, src, dst, ver};
  endfunction

  function automatic logic [IN_DATA_W-1:0] rand_word();
    logic [95:0] r;
    r = {$urandom, $urandom, $urandom};
    return r[IN_DATA_W-1:0];
  endfunction

  // offer one word; valid stays high if the next word follows at once
  task automatic send_word(input logic op, input logic [IN_DATA_W-1:0] d);
    @(negedge clk);
    while (gaps_on && $urandom_range(99) < 28) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tuser  = op;
    in_tdata  = d;
    do @(posedge clk); while (!in_tready);
    encode_word(op, d);
  endtask

  task automatic start_frame(input logic [15:0] len);
    logic [IN_DATA_W-1:0] d;
    d = rand_word();
    d[LEN_LSB +: 16] = len;
    send_word(OP_START, d);
  endtask

  task automatic pay_byte(input logic [7:0] dat);
    logic [IN_DATA_W-1:0] d;
    d = rand_word();
    d[DATA_LSB +: 8] = dat;
    send_word(OP_PAYLOAD, d);
  endtask

  // drop valid, then wait for every predicted byte and the pipeline to empty
  task automatic settle();
    @(negedge clk);
    in_tvalid = 1'b0;
    while (frame_bytes_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [15:0] val);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == REG_CRC_INIT) begin
      pred_crc_init = val;
    end else begin
      pred_max_len = val;
    end
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // field extremes and the error cases under reset settings
  task automatic test_directed_fields();
    // all-zero header with empty payload, crc straight after the header
    send_word(OP_START, pack_word(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 16'h0000, 16'h0000, 8'h00));
    send_word(OP_START, pack_word(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 16'hFFFF, 16'h0003, 8'hFF));
    pay_byte(8'h00);
    pay_byte(8'hFF);
    pay_byte(8'h5A);
    // payload with no frame open
    pay_byte(8'h3C);
    // length just over the limit, then a stray byte
    start_frame(16'd1025);
    pay_byte(8'h11);
    // length at the limit, abandoned by a new start
    start_frame(16'd1024);
    pay_byte(8'hA5);
    pay_byte(8'h81);
    start_frame(16'd1);
    // unused header fields all ones on a payload word
    send_word(OP_PAYLOAD, pack_word(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF, 8'h80));
  endtask

  // register extremes
  task automatic test_config_extremes();
    settle();
    write_reg(REG_CRC_INIT, 16'h0000);
    write_reg(REG_MAX_PAYLOAD, 16'h0000);
    start_frame(16'd0);
    start_frame(16'd1);
    settle();
    write_reg(REG_CRC_INIT, 16'hFFFF);
    write_reg(REG_MAX_PAYLOAD, 16'hFFFF);
    start_frame(16'hFFFF);
    pay_byte(8'h01);
    pay_byte(8'hFE);
    start_frame(16'd2);
    pay_byte(8'h7F);
    pay_byte(8'h80);
    settle();
    write_reg(REG_CRC_INIT, 16'h1D0F);
    write_reg(REG_MAX_PAYLOAD, MAX_PAYLOAD_RST);
  endtask

  // back-to-back words on both sides
  task automatic test_no_gaps();
    int len;
    gaps_on = 1'b0;
    for (int f = 0; f < 5; f++) begin
      len = $urandom_range(0, 10);
      start_frame(16'(len));
      for (int i = 0; i < len; i++) begin
        pay_byte(8'($urandom));
      end
    end
    settle();
    gaps_on = 1'b1;
  endtask

  // output held off while input keeps coming, so the queue fills and stalls
  task automatic test_output_hold();
    hold_left = 300;
    start_frame(16'd30);
    for (int i = 0; i < 30; i++) begin
      pay_byte(8'($urandom));
    end
    settle();
  endtask

  // mostly well-formed frames with random content, some cut short, some noise
  task automatic test_random_frames();
    int sent;
    int len;
    int cut;
    for (int ph = 0; ph < 3; ph++) begin
      settle();
      write_reg(REG_CRC_INIT, 16'($urandom));
      case (ph)
        0: begin
          write_reg(REG_MAX_PAYLOAD, 16'($urandom_range(0, 12)));
        end
        1: begin
          write_reg(REG_MAX_PAYLOAD, 16'hFFFF);
        end
        default: begin
          write_reg(REG_MAX_PAYLOAD, 16'($urandom));
        end
      endcase
      sent = 0;
      while (sent < 8) begin
        if ($urandom_range(99) < 80) begin
          len = ($urandom_range(9) == 0) ? $urandom_range(9, 24) : $urandom_range(0, 8);
          cut = ($urandom_range(9) == 0) ? $urandom_range(0, len) : len;
          start_frame(16'(len));
          for (int i = 0; i < cut; i++) begin
            pay_byte(8'($urandom));
          end
          sent += 1 + cut;
        end else begin
          send_word($urandom_range(1) ? OP_PAYLOAD : OP_START, rand_word());
          sent++;
        end
      end
    end
  endtask

  // main sequence
  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    test_directed_fields();
    test_config_extremes();
    test_no_gaps();
    test_output_hold();
    test_random_frames();
    settle();
    if (mismatch_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
